// File: rtl/core/tse_pkg.sv
// ----------------------------------------------------------------------------
// tse_pkg
// Shared constants and types of the touch slot event generator.
// ----------------------------------------------------------------------------
package tse_pkg;

    localparam int NUM_SLOTS   = 10;
    localparam int SLOT_IDX_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int SLOT_W      = 4;
    localparam int COORD_W     = 15;
    localparam int PRES_W      = 16;
    localparam int STORE_W     = 16;
    localparam int KIND_W      = 2;

    localparam logic [STORE_W-1:0] NOT_SEEN = '1;

    typedef enum logic [KIND_W-1:0] {
        KIND_X       = 2'd0,
        KIND_Y       = 2'd1,
        KIND_PRESS   = 2'd2,
        KIND_RELEASE = 2'd3
    } kind_t;

    // Event bit positions within a run.
    localparam int EV_X = 0;
    localparam int EV_Y = 1;
    localparam int EV_P = 2;

    // One sample's worth of pending events.
    typedef struct packed {
        logic [2:0]         mask;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               release_ev;
        logic [SLOT_W-1:0]  slot;
    } run_t;

endpackage

// File: rtl/core/tse_event_gen.sv
// ----------------------------------------------------------------------------
// tse_event_gen
// Per-slot contact state and comparison of one sample against it.
// ----------------------------------------------------------------------------
module tse_event_gen (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   fire,
    input  logic [3:0]             active_slots,
    input  logic [tse_pkg::SLOT_W-1:0]  slot,
    input  logic                   sample_valid,
    input  logic [tse_pkg::COORD_W-1:0] x_coord,
    input  logic [tse_pkg::COORD_W-1:0] y_coord,
    input  logic [tse_pkg::PRES_W-1:0]  pressure,
    output tse_pkg::run_t          run
);
    import tse_pkg::*;

    logic [STORE_W-1:0] last_x_reg [NUM_SLOTS];
    logic [STORE_W-1:0] last_y_reg [NUM_SLOTS];
    logic [PRES_W-1:0]  last_p_reg [NUM_SLOTS];

    logic [SLOT_IDX_W-1:0] idx;
    logic                  slot_ok;
    logic                  p_nz;
    logic                  x_diff;
    logic                  y_diff;
    logic                  p_diff;

    always_comb
    begin
        idx     = SLOT_IDX_W'(slot);
        slot_ok = sample_valid && (slot < active_slots) && (32'(slot) < NUM_SLOTS);
        p_nz    = (pressure != '0);
        x_diff  = ({1'b0, x_coord} != last_x_reg[idx]);
        y_diff  = ({1'b0, y_coord} != last_y_reg[idx]);
        p_diff  = (pressure != last_p_reg[idx]);

        run.mask[EV_X]  = slot_ok && p_nz && x_diff;
        run.mask[EV_Y]  = slot_ok && p_nz && y_diff;
        run.mask[EV_P]  = slot_ok && p_diff;
        run.x           = x_coord;
        run.y           = y_coord;
        run.release_ev  = !p_nz;
        run.slot        = slot;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                last_x_reg[i] <= NOT_SEEN;
                last_y_reg[i] <= NOT_SEEN;
                last_p_reg[i] <= '0;
            end
        end
        else if (fire && slot_ok)
        begin
            if (p_nz)
            begin
                if (x_diff)
                begin
                    last_x_reg[idx] <= {1'b0, x_coord};
                end
                if (y_diff)
                begin
                    last_y_reg[idx] <= {1'b0, y_coord};
                end
            end
            else
            begin
                last_x_reg[idx] <= NOT_SEEN;
                last_y_reg[idx] <= NOT_SEEN;
            end
            last_p_reg[idx] <= pressure;
        end
    end

endmodule

// File: rtl/core/tse_event_buf.sv
// ----------------------------------------------------------------------------
// tse_event_buf
// Holds a sample's pending events; presents one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module tse_event_buf (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         load,
    input  tse_pkg::run_t                run,
    output logic                         can_load,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [tse_pkg::KIND_W-1:0]   event_kind,
    output logic [tse_pkg::COORD_W-1:0]  axis_value,
    output logic [tse_pkg::SLOT_W-1:0]   event_slot,
    output logic                         last_of_run
);
    import tse_pkg::*;

    logic [2:0]         mask_reg;
    logic [2:0]         mask_next;
    logic [2:0]         mask_pop;
    logic [COORD_W-1:0] x_reg;
    logic [COORD_W-1:0] y_reg;
    logic               release_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic               pop;
    kind_t              kind;

    always_comb
    begin
        out_valid   = (mask_reg != '0);
        pop         = out_valid && out_ready;
        mask_pop    = mask_reg & (mask_reg - 3'd1);
        last_of_run = (mask_pop == '0);
        can_load    = !out_valid || (pop && last_of_run);

        priority if (mask_reg[EV_X])
        begin
            kind       = KIND_X;
            axis_value = x_reg;
        end
        else if (mask_reg[EV_Y])
        begin
            kind       = KIND_Y;
            axis_value = y_reg;
        end
        else
        begin
            kind       = release_reg ? KIND_RELEASE : KIND_PRESS;
            axis_value = '0;
        end
        event_kind = kind;
        event_slot = slot_reg;

        if (load)
        begin
            mask_next = run.mask;
        end
        else if (pop)
        begin
            mask_next = mask_pop;
        end
        else
        begin
            mask_next = mask_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else
        begin
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            x_reg       <= run.x;
            y_reg       <= run.y;
            release_reg <= run.release_ev;
            slot_reg    <= run.slot;
        end
    end

endmodule

// File: rtl/core/touch_slot_event_generator.sv
// ----------------------------------------------------------------------------
// touch_slot_event_generator
// Turns multi-touch contact samples into X/Y motion and press/release events.
// ----------------------------------------------------------------------------
// With the event buffer free, a sample's first event is presented once the sample
// has passed the input register and been loaded into the event buffer.
// Throughput: a sample's events (up to three) occupy the event buffer until the
// last is taken, the next sample waiting in the input register meanwhile; with
// out_ready high, samples with at most one event go one per cycle.
// Reset (rst_n, asynchronous): per-slot coordinates go to the not-seen marker,
// pressures to zero, active_slots to one, and no transaction is pending.
// ----------------------------------------------------------------------------
module touch_slot_event_generator (
    input  logic                         clk,
    input  logic                         rst_n,
    // Configuration: active slot count.
    input  logic                         cfg_wr_en,
    input  logic [3:0]                   cfg_wr_data,
    // Sample channel.
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [tse_pkg::SLOT_W-1:0]   slot,
    input  logic                         sample_valid,
    input  logic [tse_pkg::COORD_W-1:0]  x_coord,
    input  logic [tse_pkg::COORD_W-1:0]  y_coord,
    input  logic [tse_pkg::PRES_W-1:0]   pressure,
    // Event channel.
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [tse_pkg::KIND_W-1:0]   event_kind,
    output logic [tse_pkg::COORD_W-1:0]  axis_value,
    output logic [tse_pkg::SLOT_W-1:0]   event_slot,
    output logic                         last_of_run
);
    import tse_pkg::*;

    // The input register holds one accepted sample. The sample is compared
    // against the slot state and handed to the event buffer in the cycle the
    // buffer can take it; the slot state is updated at that same edge, so the
    // next sample always sees the state left by the previous one.
    logic                in_valid_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic                sample_valid_reg;
    logic [COORD_W-1:0]  x_reg;
    logic [COORD_W-1:0]  y_reg;
    logic [PRES_W-1:0]   pressure_reg;
    logic [3:0]          active_slots_reg;

    logic                fire;
    logic                buf_can_load;
    run_t                run;

    assign fire     = in_valid_reg && buf_can_load;
    assign in_ready = !in_valid_reg || fire;

    // A slot count above the number of implemented slots is not taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_slots_reg <= 4'd1;
        end
        else if (cfg_wr_en && (32'(cfg_wr_data) <= NUM_SLOTS))
        begin
            active_slots_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            slot_reg         <= slot;
            sample_valid_reg <= sample_valid;
            x_reg            <= x_coord;
            y_reg            <= y_coord;
            pressure_reg     <= pressure;
        end
    end

    tse_event_gen u_gen (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (fire),
        .active_slots (active_slots_reg),
        .slot         (slot_reg),
        .sample_valid (sample_valid_reg),
        .x_coord      (x_reg),
        .y_coord      (y_reg),
        .pressure     (pressure_reg),
        .run          (run)
    );

    // A sample that causes no events loads an empty run, which simply
    // leaves the buffer idle.
    tse_event_buf u_buf (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (fire),
        .run         (run),
        .can_load    (buf_can_load),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .event_kind  (event_kind),
        .axis_value  (axis_value),
        .event_slot  (event_slot),
        .last_of_run (last_of_run)
    );

endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the touch slot event generator. Contact samples are
// queued by a stimulus process, offered by a falling-edge driver and checked
// at the rising edge against an event predictor that keeps per-slot state.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tse_pkg::*;

    // The run is ended as failed if it gets this far. The slowest correct run
    // (88 percent idling on one side, three events per sample, the long output
    // stall) stays well under this limit.
    localparam int CYCLE_LIMIT  = 200000;
    // Cycles left to pass after the last expected event before the block is
    // taken as idle. A sample's first event comes out only after the input register
    // and the event buffer, so one with no events is long finished after this many.
    localparam int DRAIN_CYCLES = 12;
    // Length of the deliberate output stall.
    localparam int HOLD_CYCLES  = 400;

    // One contact sample as it goes into the block.
    typedef struct {
        logic [SLOT_W-1:0]  slot;
        logic               sample_valid;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [PRES_W-1:0]  pressure;
    } touch_sample_t;

    // One event as it comes out of the block.
    typedef struct {
        kind_t              kind;
        logic [COORD_W-1:0] axis;
        logic [SLOT_W-1:0]  slot;
        logic               last;
    } touch_event_t;

    // ------------------------------------------------------------------------
    // Clock, reset and block ports. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic               cfg_wr_en    = 1'b0;
    logic [3:0]         cfg_wr_data  = '0;
    logic               in_valid     = 1'b0;
    logic               in_ready;
    logic [SLOT_W-1:0]  slot         = '0;
    logic               sample_valid = 1'b0;
    logic [COORD_W-1:0] x_coord      = '0;
    logic [COORD_W-1:0] y_coord      = '0;
    logic [PRES_W-1:0]  pressure     = '0;
    logic               out_valid;
    logic               out_ready    = 1'b0;
    logic [KIND_W-1:0]  event_kind;
    logic [COORD_W-1:0] axis_value;
    logic [SLOT_W-1:0]  event_slot;
    logic               last_of_run;

    always #5 clk = ~clk;

    touch_slot_event_generator uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .slot         (slot),
        .sample_valid (sample_valid),
        .x_coord      (x_coord),
        .y_coord      (y_coord),
        .pressure     (pressure),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .event_kind   (event_kind),
        .axis_value   (axis_value),
        .event_slot   (event_slot),
        .last_of_run  (last_of_run)
    );

    // ------------------------------------------------------------------------
    // Bench state.
    // ------------------------------------------------------------------------
    touch_sample_t pending_samples [$];   // Samples waiting for the driver.
    touch_event_t  expected_events [$];   // Predicted events not yet seen.

    int  pushed_count   = 0;              // Samples handed to the driver.
    int  accepted_count = 0;              // Samples the block has taken.
    int  mismatch_count = 0;
    int  cycle_count    = 0;
    int  send_idle_pct  = 0;              // Chance in percent that the sender idles.
    int  recv_idle_pct  = 0;              // Chance in percent that the receiver idles.
    bit  in_accepted    = 1'b0;           // Input transaction at the last rising edge.
    bit  hold_req       = 1'b0;           // Asks the stall process for a long stall.
    bit  out_hold       = 1'b0;           // Output side held off while set.

    // Predictor state: the stored coordinates and pressure of every slot and
    // the slot count the block should be using.
    logic [STORE_W-1:0] pos_x   [NUM_SLOTS];
    logic [STORE_W-1:0] pos_y   [NUM_SLOTS];
    logic [PRES_W-1:0]  pos_p   [NUM_SLOTS];
    logic [3:0]         slot_limit = 4'd1;

    // The generator remembers what it last sent per slot so that it can send
    // the same coordinates or pressure again and reach the no-change paths.
    logic [COORD_W-1:0] sent_x [16];
    logic [COORD_W-1:0] sent_y [16];
    logic [PRES_W-1:0]  sent_p [16];

    // ------------------------------------------------------------------------
    // Mismatch report: one line per mismatch, printing stops after a hundred
    // lines but the count goes on.
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < 100)
            $display("error at cycle %0d: %s is %0d, expected %0d",
                     cycle_count, what, got, want);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------------
    // Event predictor. Works out the events a sample causes, in the order
    // X motion, Y motion, press or release, and updates the per-slot state.
    // Samples that are not valid or whose slot lies outside the active slots
    // cause nothing and leave the state alone.
    // ------------------------------------------------------------------------
    task automatic predict_events(input touch_sample_t s);
        touch_event_t run [$];
        touch_event_t ev;
        if (!s.sample_valid || s.slot >= slot_limit || s.slot >= NUM_SLOTS)
            return;
        ev.slot = s.slot;
        ev.last = 1'b0;
        if (s.pressure != '0) begin
            // Touching: each coordinate that moved is reported and stored.
            if ({1'b0, s.x} != pos_x[s.slot]) begin
                ev.kind = KIND_X;
                ev.axis = s.x;
                run.push_back(ev);
                pos_x[s.slot] = {1'b0, s.x};
            end
            if ({1'b0, s.y} != pos_y[s.slot]) begin
                ev.kind = KIND_Y;
                ev.axis = s.y;
                run.push_back(ev);
                pos_y[s.slot] = {1'b0, s.y};
            end
        end
        else begin
            // Lifted: forget the position so the next touch reports it again.
            pos_x[s.slot] = NOT_SEEN;
            pos_y[s.slot] = NOT_SEEN;
        end
        if (s.pressure != pos_p[s.slot]) begin
            ev.kind = (s.pressure != '0) ? KIND_PRESS : KIND_RELEASE;
            ev.axis = '0;
            run.push_back(ev);
            pos_p[s.slot] = s.pressure;
        end
        foreach (run[i])
        begin
            ev = run[i];
            ev.last = (i == run.size() - 1);
            expected_events.push_back(ev);
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver, at the falling edge. A sample on offer stays put until it has
    // been taken; after that the next one is offered unless the sender idles.
    // The receiver's ready is chosen at the same edge.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        touch_sample_t s;
        if (rst_n && !(in_valid && !in_accepted)) begin
            if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s = pending_samples.pop_front();
                slot         <= s.slot;
                sample_valid <= s.sample_valid;
                x_coord      <= s.x;
                y_coord      <= s.y;
                pressure     <= s.pressure;
                in_valid     <= 1'b1;
            end
            else begin
                in_valid <= 1'b0;
            end
        end
        out_ready <= rst_n && !out_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------------
    // Monitor, at the rising edge. Events are checked before the sample taken
    // at the same edge is predicted; its events must first pass the event buffer.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        touch_event_t  want;
        touch_sample_t s;
        in_accepted = 1'b0;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (expected_events.size() == 0) begin
                    report_mismatch("event kind with nothing expected", event_kind, 0);
                end
                else begin
                    want = expected_events.pop_front();
                    if (event_kind != want.kind)
                        report_mismatch("event_kind", event_kind, want.kind);
                    if (axis_value != want.axis)
                        report_mismatch("axis_value", axis_value, want.axis);
                    if (event_slot != want.slot)
                        report_mismatch("event_slot", event_slot, want.slot);
                    if (last_of_run != want.last)
                        report_mismatch("last_of_run", last_of_run, want.last);
                end
            end
            if (in_valid && in_ready) begin
                s.slot         = slot;
                s.sample_valid = sample_valid;
                s.x            = x_coord;
                s.y            = y_coord;
                s.pressure     = pressure;
                predict_events(s);
                accepted_count++;
                in_accepted = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Long output stall, counted here in its own process. While it lasts the
    // sender keeps offering, so the event buffer fills and in_ready drops.
    // ------------------------------------------------------------------------
    always
    begin
        wait (hold_req);
        @(posedge clk);
        out_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_hold = 1'b0;
        hold_req = 1'b0;
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    task automatic push_sample(input logic [SLOT_W-1:0] s_slot, input logic s_valid,
                               input logic [COORD_W-1:0] s_x, input logic [COORD_W-1:0] s_y,
                               input logic [PRES_W-1:0] s_p);
        touch_sample_t s;
        s.slot         = s_slot;
        s.sample_valid = s_valid;
        s.x            = s_x;
        s.y            = s_y;
        s.pressure     = s_p;
        pending_samples.push_back(s);
        pushed_count++;
    endtask

    // Waits until every sample has been taken and every predicted event has
    // come out, then lets the block settle. The sender has nothing to offer
    // meanwhile, so this is also the pause of the sender.
    task automatic wait_for_drain();
        while (accepted_count != pushed_count || expected_events.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Writes the slot count; only called while the block is idle. Counts above
    // the maximum are refused by the block and leave the register unchanged.
    task automatic write_slot_count(input logic [3:0] value);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        if (value <= NUM_SLOTS)
            slot_limit = value;
    endtask

    // Queues random samples until the given number of them are ones the block
    // acts on. Most are well formed: valid, inside the active slots, with
    // coordinates and pressure often repeated from the slot's last sample so
    // that unchanged values, lifts and re-touches all occur. About one in five
    // is noise with every field random.
    task automatic queue_random_samples(input int count);
        touch_sample_t s;
        int counted;
        counted = 0;
        while (counted < count) begin
            if ($urandom_range(9) < 2) begin
                s.slot         = SLOT_W'($urandom);
                s.sample_valid = 1'($urandom);
                s.x            = COORD_W'($urandom);
                s.y            = COORD_W'($urandom);
                s.pressure     = PRES_W'($urandom);
            end
            else begin
                s.sample_valid = 1'b1;
                if (slot_limit == 0)
                    s.slot = SLOT_W'($urandom_range(15));
                else
                    s.slot = SLOT_W'($urandom_range(slot_limit - 1));
                case ($urandom_range(9))
                    0, 1, 2, 3: s.x = sent_x[s.slot];
                    4:          s.x = '0;
                    5:          s.x = '1;
                    default:    s.x = COORD_W'($urandom);
                endcase
                case ($urandom_range(9))
                    0, 1, 2, 3: s.y = sent_y[s.slot];
                    4:          s.y = '0;
                    5:          s.y = '1;
                    default:    s.y = COORD_W'($urandom);
                endcase
                case ($urandom_range(9))
                    0, 1, 2:    s.pressure = '0;
                    3, 4, 5:    s.pressure = sent_p[s.slot];
                    6:          s.pressure = '1;
                    7:          s.pressure = 16'd1;
                    default:    s.pressure = PRES_W'($urandom);
                endcase
            end
            sent_x[s.slot] = s.x;
            sent_y[s.slot] = s.y;
            sent_p[s.slot] = s.pressure;
            if (s.sample_valid && s.slot < slot_limit)
                counted++;
            push_sample(s.slot, s.sample_valid, s.x, s.y, s.pressure);
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            pos_x[i] = NOT_SEEN;
            pos_y[i] = NOT_SEEN;
            pos_p[i] = '0;
        end
        for (int i = 0; i < 16; i++) begin
            sent_x[i] = '0;
            sent_y[i] = '0;
            sent_p[i] = '0;
        end
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part. Out of reset only slot 0 is active, so the slot 1
        // sample must be ignored.
        push_sample(4'd0, 1'b1, 15'd10, 15'd20, 16'd100);
        push_sample(4'd1, 1'b1, 15'd30, 15'd40, 16'd100);
        wait_for_drain();

        write_slot_count(4'd10);
        // First touch at the origin: X, Y and press.
        push_sample(4'd2, 1'b1, 15'd0, 15'd0, 16'd1);
        // Same sample again: nothing.
        push_sample(4'd2, 1'b1, 15'd0, 15'd0, 16'd1);
        // X to full scale alone.
        push_sample(4'd2, 1'b1, 15'h7FFF, 15'd0, 16'd1);
        // Y to full scale and pressure to full scale: Y and another press.
        push_sample(4'd2, 1'b1, 15'h7FFF, 15'h7FFF, 16'hFFFF);
        // Lift: release only.
        push_sample(4'd2, 1'b1, 15'h7FFF, 15'h7FFF, 16'd0);
        // Still lifted with unchanged pressure: no events.
        push_sample(4'd2, 1'b1, 15'd5, 15'd6, 16'd0);
        // Touch again at the old spot: the position was forgotten, so X and Y
        // are reported again, then the press.
        push_sample(4'd2, 1'b1, 15'h7FFF, 15'h7FFF, 16'd5);
        // Sample marked not valid: ignored.
        push_sample(4'd9, 1'b0, 15'd100, 15'd200, 16'd7);
        // Highest slot.
        push_sample(4'd9, 1'b1, 15'd100, 15'd200, 16'hFFFF);
        // Slots at and beyond the maximum: ignored.
        push_sample(4'd10, 1'b1, 15'd1, 15'd2, 16'd3);
        push_sample(4'd15, 1'b1, 15'd1, 15'd2, 16'd3);
        // Lift on the highest slot.
        push_sample(4'd9, 1'b1, 15'd100, 15'd200, 16'd0);
        wait_for_drain();

        // Counts above the maximum are refused: slot 9 stays active.
        write_slot_count(4'd11);
        write_slot_count(4'd15);
        push_sample(4'd9, 1'b1, 15'd1, 15'd1, 16'd9);
        wait_for_drain();

        // No active slots at all: everything is ignored.
        write_slot_count(4'd0);
        push_sample(4'd0, 1'b1, 15'd3, 15'd3, 16'd3);
        push_sample(4'd9, 1'b1, 15'd4, 15'd4, 16'd4);
        wait_for_drain();

        // First random phase: sender mostly busy, receiver mostly idle.
        write_slot_count(4'd10);
        send_idle_pct = 18;
        recv_idle_pct = 88;
        queue_random_samples(86);
        wait_for_drain();

        // Second random phase: sender mostly idle, receiver mostly ready.
        write_slot_count(4'd4);
        send_idle_pct = 88;
        recv_idle_pct = 18;
        queue_random_samples(48);
        wait_for_drain();
        write_slot_count(4'd1);
        queue_random_samples(38);
        wait_for_drain();

        // Third random phase: no idling. It opens with the long output stall
        // while samples keep coming, then the sender pauses until everything
        // has drained before the rest goes out.
        write_slot_count(4'd10);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 1'b1;
        queue_random_samples(40);
        while (hold_req)
            @(negedge clk);
        wait_for_drain();
        queue_random_samples(48);
        wait_for_drain();

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: files.f
rtl/core/tse_pkg.sv
rtl/core/tse_event_gen.sv
rtl/core/tse_event_buf.sv
rtl/core/touch_slot_event_generator.sv
sim/testbench.sv
